### sv/nqr_pkg.sv
// Shared types, constants and saturating helpers for the quintic Newton root finder.
// No dependencies; every other file uses this package.
package nqr_pkg;

    localparam int WORD_W    = 64;
    localparam int FRAC_BITS = 32;
    localparam int HALF_W    = WORD_W / 2;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int NUM_W     = WORD_W + FRAC_BITS;
    localparam int CNT_W     = 16;
    localparam int TOL_W     = 32;
    localparam int ADDR_W    = 6;
    localparam int IDX_W     = 3;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [WORD_W-1:0]        mag_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [TOL_W-1:0]         tol_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [IDX_W-1:0]         idx_t;

    typedef enum logic [1:0] {
        OUT_CONVERGED  = 2'd0,
        OUT_NO_ROOT    = 2'd1,
        OUT_INCOMPLETE = 2'd2
    } outcome_t;

    typedef enum idx_t {
        REG_COEF_0 = 3'd0,
        REG_COEF_1 = 3'd1,
        REG_COEF_2 = 3'd2,
        REG_COEF_3 = 3'd3,
        REG_COEF_4 = 3'd4,
        REG_COEF_5 = 3'd5,
        REG_LIMIT  = 3'd6,
        REG_TOL    = 3'd7
    } reg_idx_t;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        word_t   a;
        word_t   b;
    } alu_req_t;

    typedef struct packed {
        logic  done;
        logic  ovf;
        word_t result;
    } alu_resp_t;

    typedef struct packed {
        logic  ovf;
        word_t val;
    } sat_t;

    localparam word_t WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_W-1){1'b0}}};

    function automatic mag_t magn(input word_t v);
        magn = v[WORD_W-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

    // Sign and magnitude to a word, saturating; big marks a magnitude past the word.
    function automatic sat_t make_word(input logic neg, input logic big, input mag_t m);
        sat_t r;
        r.ovf = 1'b0;
        r.val = '0;
        if (neg) begin
            if (big || m > mag_t'(WMIN)) begin
                r.ovf = 1'b1;
                r.val = WMIN;
            end
            else begin
                r.val = word_t'(-m);
            end
        end
        else begin
            if (big || m > mag_t'(WMAX)) begin
                r.ovf = 1'b1;
                r.val = WMAX;
            end
            else begin
                r.val = word_t'(m);
            end
        end
        return r;
    endfunction

    function automatic sat_t sat_add(input word_t a, input word_t b);
        logic [WORD_W:0] s;
        sat_t r;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        r.ovf = s[WORD_W] != s[WORD_W-1];
        r.val = r.ovf ? (s[WORD_W] ? WMIN : WMAX) : word_t'(s[WORD_W-1:0]);
        return r;
    endfunction

    function automatic sat_t sat_sub(input word_t a, input word_t b);
        logic [WORD_W:0] s;
        sat_t r;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        r.ovf = s[WORD_W] != s[WORD_W-1];
        r.val = r.ovf ? (s[WORD_W] ? WMIN : WMAX) : word_t'(s[WORD_W-1:0]);
        return r;
    endfunction

endpackage

### sv/nqr_if.sv
// Valid/ready stream interfaces for the guess channel and the result channel.
// Depends on nqr_pkg for the payload types.
interface nqr_guess_if;
    logic                valid;
    logic                ready;
    nqr_pkg::word_t      initial_guess;

    modport source (output valid, output initial_guess, input ready);
    modport sink   (input valid, input initial_guess, output ready);
endinterface

interface nqr_result_if;
    logic                valid;
    logic                ready;
    nqr_pkg::word_t      root_estimate;
    nqr_pkg::outcome_t   outcome;
    nqr_pkg::count_t     steps_taken;

    modport source (output valid, output root_estimate, output outcome, output steps_taken,
                    input ready);
    modport sink   (input valid, input root_estimate, input outcome, input steps_taken,
                    output ready);
endinterface

### sv/nqr_alu.sv
// Shared multi-cycle arithmetic unit: Q-format multiply and divide, both saturating.
// Depends on nqr_pkg.
module nqr_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  nqr_pkg::alu_req_t  req,
    output nqr_pkg::alu_resp_t resp
);
    import nqr_pkg::*;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MULP,
        A_MULA,
        A_MFIN,
        A_DIV,
        A_DFIN
    } alu_state_t;

    alu_state_t             state_reg, state_next;
    mag_t                   ma_reg, ma_next;
    mag_t                   mb_reg, mb_next;
    logic                   neg_reg, neg_next;
    logic [1:0]             k_reg, k_next;
    logic [WORD_W-1:0]      prod_reg, prod_next;
    logic [PROD_W-1:0]      acc_reg, acc_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    mag_t                   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    alu_resp_t              resp_reg, resp_next;

    logic [HALF_W-1:0]      a_part, b_part;
    logic [PROD_W-1:0]      prod_shifted;
    logic [WORD_W:0]        rem2;
    logic                   ge;
    sat_t                   fin;

    always_comb
    begin
        a_part = k_reg[1] ? ma_reg[WORD_W-1:HALF_W] : ma_reg[HALF_W-1:0];
        b_part = k_reg[0] ? mb_reg[WORD_W-1:HALF_W] : mb_reg[HALF_W-1:0];
        case (k_reg)
            2'd0:    prod_shifted = {{WORD_W{1'b0}}, prod_reg};
            2'd3:    prod_shifted = {prod_reg, {WORD_W{1'b0}}};
            default: prod_shifted = {{HALF_W{1'b0}}, prod_reg, {HALF_W{1'b0}}};
        endcase
        rem2 = {rem_reg, num_reg[NUM_W-1]};
        ge   = rem2 >= {1'b0, mb_reg};
        if (state_reg == A_MFIN)
            fin = make_word(neg_reg, acc_reg[PROD_W-1:WORD_W+FRAC_BITS] != '0,
                            acc_reg[WORD_W+FRAC_BITS-1:FRAC_BITS]);
        else
            fin = make_word(neg_reg, num_reg[NUM_W-1:WORD_W] != '0, num_reg[WORD_W-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        k_next     = k_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        resp_next  = resp_reg;
        resp_next.done = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    ma_next  = magn(req.a);
                    mb_next  = magn(req.b);
                    neg_next = req.a[WORD_W-1] != req.b[WORD_W-1];
                    k_next   = '0;
                    acc_next = '0;
                    rem_next = '0;
                    cnt_next = DIV_CNT_W'(NUM_W - 1);
                    num_next = {magn(req.a), {FRAC_BITS{1'b0}}};
                    state_next = (req.op == ALU_DIV) ? A_DIV : A_MULP;
                end
            end
            A_MULP:
            begin
                prod_next  = WORD_W'(a_part) * WORD_W'(b_part);
                state_next = A_MULA;
            end
            A_MULA:
            begin
                acc_next = acc_reg + prod_shifted;
                k_next   = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? A_MFIN : A_MULP;
            end
            A_DIV:
            begin
                rem_next = ge ? mag_t'(rem2 - {1'b0, mb_reg}) : mag_t'(rem2);
                num_next = {num_reg[NUM_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = A_DFIN;
            end
            A_MFIN, A_DFIN:
            begin
                resp_next.done   = 1'b1;
                resp_next.ovf    = fin.ovf;
                resp_next.result = fin.val;
                state_next = A_IDLE;
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            resp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
        k_reg    <= k_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    assign resp = resp_reg;

endmodule

### sv/newton_quintic_root_finder.sv
// Newton-Raphson root finder for a fifth-degree polynomial, signed Q32.32.
// Depends on nqr_pkg, nqr_if (stream interfaces) and nqr_alu.
//
// Usage:
//   Write coef_0..coef_5, iteration_limit and step_tolerance over the APB port
//   (register i at byte address 8*i, 64-bit data) while the block is idle.
//   Each transfer on the guess channel starts one search and yields exactly one
//   transfer on the result channel: root_estimate, outcome, steps_taken.
//   guess.ready is high only while no search runs; a finished result sits in an
//   output register, so the next guess is taken while that result still waits.
//   Sequence: derivative-coefficient setup, then per Newton step 9 multiplies
//   in the shared unit, one restoring divide and the sequencing states around
//   them. Most of each step is spent in the shared multiply/divide unit.
//   When the receiver stalls, the result holds; a search that finishes while the
//   previous result is still unclaimed waits until it is taken.
//   Reset clears the registers to coefficients 0, limit 1000, tolerance 4295,
//   and empties both channels.
module newton_quintic_root_finder (
    input  logic                  clk,
    input  logic                  rst_n,
    nqr_guess_if.sink             guess,
    nqr_result_if.source          result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  nqr_pkg::addr_t        paddr,
    input  nqr_pkg::word_t        pwdata,
    output nqr_pkg::word_t        prdata,
    output logic                  pready
);
    import nqr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_FMUL,
        S_FWAIT,
        S_DMUL,
        S_DWAIT,
        S_CHECK,
        S_DIV,
        S_DIVW,
        S_STEP,
        S_DONE
    } state_t;

    // configuration registers
    word_t    coef_reg [6];
    count_t   limit_reg;
    tol_t     tol_reg;
    reg_idx_t wr_idx;

    // sequencer
    state_t   state_reg, state_next;
    word_t    x_reg, x_next;
    word_t    f_reg, f_next;
    word_t    d_reg, d_next;
    word_t    q_reg, q_next;
    word_t    acc_reg, acc_next;
    word_t    dc_reg [2:5];
    word_t    dc_next [2:5];
    idx_t     idx_reg, idx_next;
    idx_t     pk_reg, pk_next;
    count_t   cnt_reg, cnt_next;
    logic     ovf_reg, ovf_next;
    word_t    root_reg, root_next;
    outcome_t stat_reg, stat_next;

    // output register
    logic     out_valid_reg, out_valid_next;
    word_t    out_root_reg, out_root_next;
    outcome_t out_stat_reg, out_stat_next;
    count_t   out_cnt_reg, out_cnt_next;

    alu_req_t  alu_req;
    alu_resp_t alu_resp;

    word_t    coef_sel;
    word_t    dc_sel;
    sat_t     s_prep, s_f, s_d, s_step;
    logic     cfg_wr;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                coef_reg[i] <= '0;
            limit_reg <= count_t'(1000);
            tol_reg   <= tol_t'(4295);
        end
        else if (cfg_wr)
        begin
            case (wr_idx)
                REG_COEF_0: coef_reg[0] <= pwdata;
                REG_COEF_1: coef_reg[1] <= pwdata;
                REG_COEF_2: coef_reg[2] <= pwdata;
                REG_COEF_3: coef_reg[3] <= pwdata;
                REG_COEF_4: coef_reg[4] <= pwdata;
                REG_COEF_5: coef_reg[5] <= pwdata;
                REG_LIMIT:  limit_reg   <= count_t'(pwdata[CNT_W-1:0]);
                REG_TOL:    tol_reg     <= tol_t'(pwdata[TOL_W-1:0]);
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            REG_COEF_0: prdata = coef_reg[0];
            REG_COEF_1: prdata = coef_reg[1];
            REG_COEF_2: prdata = coef_reg[2];
            REG_COEF_3: prdata = coef_reg[3];
            REG_COEF_4: prdata = coef_reg[4];
            REG_COEF_5: prdata = coef_reg[5];
            REG_LIMIT:  prdata = word_t'({{(WORD_W-CNT_W){1'b0}}, limit_reg});
            REG_TOL:    prdata = word_t'({{(WORD_W-TOL_W){1'b0}}, tol_reg});
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- shared unit
    nqr_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .resp  (alu_resp)
    );

    always_comb
    begin
        alu_req.start = (state_reg == S_FMUL) || (state_reg == S_DMUL) || (state_reg == S_DIV);
        alu_req.op    = (state_reg == S_DIV) ? ALU_DIV : ALU_MUL;
        case (state_reg)
            S_DMUL:  alu_req.a = d_reg;
            S_DIV:   alu_req.a = f_reg;
            default: alu_req.a = f_reg;
        endcase
        alu_req.b = (state_reg == S_DIV) ? d_reg : x_reg;
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        coef_sel = coef_reg[idx_reg];
        dc_sel   = (idx_reg < 3'd2) ? coef_reg[1] : dc_reg[idx_reg];
        s_prep   = sat_add(acc_reg, coef_sel);
        s_f      = sat_add(alu_resp.result, coef_sel);
        s_d      = sat_add(alu_resp.result, dc_sel);
        s_step   = sat_sub(x_reg, q_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        f_next     = f_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        acc_next   = acc_reg;
        dc_next    = dc_reg;
        idx_next   = idx_reg;
        pk_next    = pk_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        root_next  = root_reg;
        stat_next  = stat_reg;

        out_valid_next = out_valid_reg && !result.ready;
        out_root_next  = out_root_reg;
        out_stat_next  = out_stat_reg;
        out_cnt_next   = out_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (guess.valid)
                begin
                    x_next   = guess.initial_guess;
                    cnt_next = '0;
                    ovf_next = 1'b0;
                    acc_next = '0;
                    idx_next = 3'd2;
                    pk_next  = '0;
                    state_next = S_PREP;
                end
            end
            // build i*a[i] for i = 2..5 by repeated saturating adds
            S_PREP:
            begin
                ovf_next = ovf_reg || s_prep.ovf;
                if (pk_reg + 3'd1 == idx_reg)
                begin
                    dc_next[idx_reg] = s_prep.val;
                    acc_next = '0;
                    pk_next  = '0;
                    if (idx_reg == 3'd5)
                    begin
                        f_next   = coef_reg[5];
                        idx_next = 3'd4;
                        state_next = S_FMUL;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                else
                begin
                    acc_next = s_prep.val;
                    pk_next  = pk_reg + 3'd1;
                end
            end
            S_FMUL: state_next = S_FWAIT;
            S_FWAIT:
            begin
                if (alu_resp.done)
                begin
                    f_next   = s_f.val;
                    ovf_next = ovf_reg || alu_resp.ovf || s_f.ovf;
                    if (idx_reg == '0)
                    begin
                        d_next   = dc_reg[5];
                        idx_next = 3'd4;
                        state_next = S_DMUL;
                    end
                    else
                    begin
                        idx_next = idx_reg - 3'd1;
                        state_next = S_FMUL;
                    end
                end
            end
            S_DMUL: state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (alu_resp.done)
                begin
                    d_next   = s_d.val;
                    ovf_next = ovf_reg || alu_resp.ovf || s_d.ovf;
                    if (idx_reg == 3'd1)
                        state_next = S_CHECK;
                    else
                    begin
                        idx_next = idx_reg - 3'd1;
                        state_next = S_DMUL;
                    end
                end
            end
            S_CHECK:
            begin
                if (cnt_reg >= limit_reg)
                begin
                    stat_next = OUT_INCOMPLETE;
                    cnt_next  = limit_reg;
                    state_next = S_DONE;
                end
                else if (d_reg == '0 || ovf_reg)
                begin
                    stat_next = OUT_NO_ROOT;
                    state_next = S_DONE;
                end
                else if (x_reg == '0 && f_reg == '0)
                begin
                    stat_next = OUT_CONVERGED;
                    root_next = '0;
                    state_next = S_DONE;
                end
                else
                    state_next = S_DIV;
            end
            S_DIV: state_next = S_DIVW;
            S_DIVW:
            begin
                if (alu_resp.done)
                begin
                    q_next   = alu_resp.result;
                    ovf_next = ovf_reg || alu_resp.ovf;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (ovf_reg || s_step.ovf)
                begin
                    stat_next = OUT_NO_ROOT;
                    state_next = S_DONE;
                end
                else if (magn(q_reg) < mag_t'(tol_reg))
                begin
                    stat_next = OUT_CONVERGED;
                    root_next = s_step.val;
                    cnt_next  = cnt_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    x_next   = s_step.val;
                    f_next   = coef_reg[5];
                    idx_next = 3'd4;
                    state_next = S_FMUL;
                end
            end
            // hold the finished result until the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_root_next  = (stat_reg == OUT_CONVERGED) ? root_reg : '0;
                    out_stat_next  = stat_reg;
                    out_cnt_next   = cnt_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        f_reg    <= f_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        dc_reg   <= dc_next;
        idx_reg  <= idx_next;
        pk_reg   <= pk_next;
        cnt_reg  <= cnt_next;
        ovf_reg  <= ovf_next;
        root_reg <= root_next;
        stat_reg <= stat_next;
        out_root_reg <= out_root_next;
        out_stat_reg <= out_stat_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign guess.ready          = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.root_estimate = out_root_reg;
    assign result.outcome       = out_stat_reg;
    assign result.steps_taken   = out_cnt_reg;

    // ---------------------------------------------------------------- checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        guess.valid && guess.ready |=> !guess.ready)
        else $error("guess taken while a search was starting");

    a_root_zero_unless_converged: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.outcome != OUT_CONVERGED |-> result.root_estimate == '0)
        else $error("nonzero root on a failed search");

    a_alu_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        alu_resp.done |-> (state_reg == S_FWAIT || state_reg == S_DWAIT
                           || state_reg == S_DIVW))
        else $error("arithmetic result arrived with no one waiting");

endmodule
